// ===== rtl/egc_pkg.sv =====
// Shared constants, types and the colour ring of the elevation gradient colour map.
package egc_pkg;

    // Defaults for the top level parameters
    localparam int SEGMENTS_DEF  = 6;
    localparam int FRAC_BITS_DEF = 16;

    // Fixed field widths
    localparam int ELEV_W    = 16;
    localparam int COLOR_W   = 24;
    localparam int CH_W      = 8;
    localparam int CHANNELS  = 3;
    localparam int CFG_IDX_W = 1;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ELEV_MIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ELEV_MAX = 1'd1;

    // Register reset values
    localparam logic [ELEV_W-1:0] ELEV_MIN_RST = 16'd0;
    localparam logic [ELEV_W-1:0] ELEV_MAX_RST = 16'd255;

    // Hue ring: magenta, red, yellow, green, cyan, blue, magenta
    localparam int RING_COLORS = 6;
    localparam int SLOT_W      = 3;
    localparam int SEG_IN_W    = 5;
    localparam logic [COLOR_W-1:0] HUE_RING [0:RING_COLORS] = '{
        24'hFF00FF, 24'hFF0000, 24'hFFFF00, 24'h00FF00,
        24'h00FFFF, 24'h0000FF, 24'hFF00FF
    };

    // Control bits that travel with each item through the divider
    typedef struct packed {
        logic flag;     // sample outside range or range empty
        logic bad;      // maximum not above minimum
        logic sat_one;  // fraction forced to exactly one
    } ctl_t;

    // Segment number modulo the ring length; segment numbers stay below three rings
    function automatic logic [SLOT_W-1:0] ring_slot(input logic [SEG_IN_W-1:0] seg);
        logic [SEG_IN_W-1:0] v;
        v = seg;
        for (int i = 0; i < 2; i++)
        begin
            if (v >= SEG_IN_W'(RING_COLORS))
            begin
                v = v - SEG_IN_W'(RING_COLORS);
            end
        end
        return v[SLOT_W-1:0];
    endfunction

endpackage

// ===== rtl/egc_norm.sv =====
// Front stage: range check, saturation decisions and divider operand set-up.
module egc_norm #(
    parameter int FRAC_BITS = egc_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [egc_pkg::ELEV_W-1:0]     altitude,
    input  logic signed [egc_pkg::ELEV_W-1:0]     elev_min,
    input  logic signed [egc_pkg::ELEV_W:0]       den,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [egc_pkg::ELEV_W+FRAC_BITS-1:0]  out_acc,
    output egc_pkg::ctl_t                         out_ctl
);
    localparam int ACC_W = egc_pkg::ELEV_W + FRAC_BITS;

    logic signed [egc_pkg::ELEV_W:0] num;
    logic                            below;
    logic                            above;
    logic                            full;
    logic                            bad;
    logic [egc_pkg::ELEV_W-1:0]      rem0;
    logic [ACC_W-1:0]                acc_next;
    egc_pkg::ctl_t                   ctl_next;
    logic                            valid_reg;
    logic [ACC_W-1:0]                acc_reg;
    egc_pkg::ctl_t                   ctl_reg;

    // Classify the sample against the configured range
    always_comb
    begin
        num   = {altitude[egc_pkg::ELEV_W-1], altitude}
              - {elev_min[egc_pkg::ELEV_W-1], elev_min};
        bad   = den[egc_pkg::ELEV_W] || (den == '0);
        below = num[egc_pkg::ELEV_W];
        above = !below && (num > den);
        full  = (num == den);
        rem0  = (bad || below || above || full) ? '0 : num[egc_pkg::ELEV_W-1:0];
        acc_next = {rem0, {FRAC_BITS{1'b0}}};
        ctl_next.flag    = bad || below || above;
        ctl_next.bad     = bad;
        ctl_next.sat_one = above || full;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_acc   = acc_reg;
    assign out_ctl   = ctl_reg;

    // Advance the valid bit when this stage is empty or the next stage has room
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Load the payload with each accepted item
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            acc_reg <= acc_next;
            ctl_reg <= ctl_next;
        end
    end

endmodule

// ===== rtl/egc_div_stage.sv =====
// One restoring division step: one quotient bit of the normalized fraction.
module egc_div_stage #(
    parameter int FRAC_BITS = egc_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [egc_pkg::ELEV_W+FRAC_BITS-1:0]  in_acc,
    input  egc_pkg::ctl_t                         in_ctl,
    input  logic [egc_pkg::ELEV_W-1:0]            den,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [egc_pkg::ELEV_W+FRAC_BITS-1:0]  out_acc,
    output egc_pkg::ctl_t                         out_ctl
);
    localparam int ACC_W = egc_pkg::ELEV_W + FRAC_BITS;

    logic [egc_pkg::ELEV_W:0]   rem2;
    logic [egc_pkg::ELEV_W:0]   diff;
    logic                       ge;
    logic [egc_pkg::ELEV_W-1:0] rem_n;
    logic [ACC_W-1:0]           acc_next;
    logic                       valid_reg;
    logic [ACC_W-1:0]           acc_reg;
    egc_pkg::ctl_t              ctl_reg;

    // Shift the remainder, trial-subtract the divisor, shift in the quotient bit
    always_comb
    begin
        rem2     = in_acc[ACC_W-1:FRAC_BITS-1];
        diff     = rem2 - {1'b0, den};
        ge       = (rem2 >= {1'b0, den});
        rem_n    = ge ? diff[egc_pkg::ELEV_W-1:0] : rem2[egc_pkg::ELEV_W-1:0];
        acc_next = {rem_n, in_acc[FRAC_BITS-2:0], ge};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_acc   = acc_reg;
    assign out_ctl   = ctl_reg;

    // Advance the valid bit when this stage is empty or the next stage has room
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Load the payload with each accepted item
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            acc_reg <= acc_next;
            ctl_reg <= in_ctl;
        end
    end

endmodule

// ===== rtl/egc_lerp.sv =====
// Back end: segment split, colour lookup, per-channel interpolation and output register.
module egc_lerp #(
    parameter int SEGMENTS  = egc_pkg::SEGMENTS_DEF,
    parameter int FRAC_BITS = egc_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [FRAC_BITS-1:0]          in_q,
    input  egc_pkg::ctl_t                 in_ctl,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [egc_pkg::COLOR_W-1:0]   rgb_color,
    output logic                          range_flag
);
    localparam int FW     = FRAC_BITS + 1;
    localparam int SI_W   = $clog2(SEGMENTS + 1);
    localparam int SCL_W  = FRAC_BITS + SI_W;
    localparam int CH_W   = egc_pkg::CH_W;
    localparam int NCH    = egc_pkg::CHANNELS;
    localparam int PROD_W = CH_W + FW;
    localparam logic [FW-1:0]     F_ONE    = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [PROD_W:0]   ROUND_UP = (PROD_W+1)'({FRAC_BITS{1'b1}});
    localparam logic [SI_W-1:0]   SEG_TOP  = SI_W'(SEGMENTS - 1);

    // Stage valid bits and the ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    // Stage 1: scaled fraction
    logic [FW-1:0]    f;
    logic [SCL_W-1:0] scaled_next;
    logic [SCL_W-1:0] s1_scaled_reg;
    logic             s1_flag_reg;
    logic             s1_bad_reg;

    // Stage 2: segment, position and end colours
    logic [SI_W-1:0]            seg_raw;
    logic [SI_W-1:0]            seg_c;
    logic [SCL_W-1:0]           t_full;
    logic [egc_pkg::SLOT_W-1:0] slot;
    logic [egc_pkg::SLOT_W-1:0] slot_end;
    logic [egc_pkg::COLOR_W-1:0] col_a;
    logic [egc_pkg::COLOR_W-1:0] col_b;
    logic [CH_W-1:0] a_next    [NCH];
    logic [CH_W-1:0] diff_next [NCH];
    logic            up_next   [NCH];
    logic [FW-1:0]   s2_t_reg;
    logic [CH_W-1:0] s2_a_reg    [NCH];
    logic [CH_W-1:0] s2_diff_reg [NCH];
    logic            s2_up_reg   [NCH];
    logic            s2_flag_reg;
    logic            s2_bad_reg;

    // Stage 3: products
    logic [PROD_W-1:0] p_next   [NCH];
    logic [PROD_W-1:0] s3_p_reg [NCH];
    logic [CH_W-1:0]   s3_a_reg [NCH];
    logic              s3_up_reg[NCH];
    logic              s3_flag_reg;
    logic              s3_bad_reg;

    // Stage 4: channel results
    logic [PROD_W:0]             p_round [NCH];
    logic [CH_W-1:0]             ch_next [NCH];
    logic [egc_pkg::COLOR_W-1:0] rgb_next;
    logic [egc_pkg::COLOR_W-1:0] s4_rgb_reg;
    logic                        s4_flag_reg;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Scale the fraction by the segment count
    always_comb
    begin
        f           = in_ctl.sat_one ? F_ONE : {1'b0, in_q};
        scaled_next = SCL_W'(f) * SCL_W'(SEGMENTS);
    end

    // Split into segment and position, look up the end colours
    always_comb
    begin
        seg_raw  = s1_scaled_reg[SCL_W-1:FRAC_BITS];
        seg_c    = (seg_raw > SEG_TOP) ? SEG_TOP : seg_raw;
        t_full   = s1_scaled_reg - {seg_c, {FRAC_BITS{1'b0}}};
        slot     = egc_pkg::ring_slot(egc_pkg::SEG_IN_W'(seg_c));
        slot_end = slot + egc_pkg::SLOT_W'(1);
        col_a    = egc_pkg::HUE_RING[slot];
        col_b    = egc_pkg::HUE_RING[slot_end];
        for (int c = 0; c < NCH; c++)
        begin
            a_next[c]    = col_a[c*CH_W +: CH_W];
            up_next[c]   = (col_b[c*CH_W +: CH_W] >= col_a[c*CH_W +: CH_W]);
            diff_next[c] = up_next[c] ? (col_b[c*CH_W +: CH_W] - col_a[c*CH_W +: CH_W])
                                      : (col_a[c*CH_W +: CH_W] - col_b[c*CH_W +: CH_W]);
        end
    end

    // Multiply each channel step by the position
    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            p_next[c] = PROD_W'(s2_diff_reg[c]) * PROD_W'(s2_t_reg);
        end
    end

    // Round the result down: floor when rising, ceiling of the drop when falling
    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            p_round[c] = {1'b0, s3_p_reg[c]} + ROUND_UP;
            ch_next[c] = s3_up_reg[c]
                       ? (s3_a_reg[c] + s3_p_reg[c][FRAC_BITS +: CH_W])
                       : (s3_a_reg[c] - p_round[c][FRAC_BITS +: CH_W]);
        end
        rgb_next = s3_bad_reg ? egc_pkg::HUE_RING[0] : {ch_next[2], ch_next[1], ch_next[0]};
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Load each stage's payload when an item moves in
    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            s1_scaled_reg <= scaled_next;
            s1_flag_reg   <= in_ctl.flag;
            s1_bad_reg    <= in_ctl.bad;
        end
        if (rdy2 && v1_reg)
        begin
            s2_t_reg    <= t_full[FW-1:0];
            s2_flag_reg <= s1_flag_reg;
            s2_bad_reg  <= s1_bad_reg;
            for (int c = 0; c < NCH; c++)
            begin
                s2_a_reg[c]    <= a_next[c];
                s2_diff_reg[c] <= diff_next[c];
                s2_up_reg[c]   <= up_next[c];
            end
        end
        if (rdy3 && v2_reg)
        begin
            s3_flag_reg <= s2_flag_reg;
            s3_bad_reg  <= s2_bad_reg;
            for (int c = 0; c < NCH; c++)
            begin
                s3_p_reg[c]  <= p_next[c];
                s3_a_reg[c]  <= s2_a_reg[c];
                s3_up_reg[c] <= s2_up_reg[c];
            end
        end
        if (rdy4 && v3_reg)
        begin
            s4_rgb_reg  <= rgb_next;
            s4_flag_reg <= s3_flag_reg;
        end
    end

    assign out_valid  = v4_reg;
    assign rgb_color  = s4_rgb_reg;
    assign range_flag = s4_flag_reg;

endmodule

// ===== rtl/elevation_gradient_colormap.sv =====
// Top level of the elevation gradient colour map: configuration registers and pipeline.
//
//   channel   direction  handshake                 payload
//   s_axis    in         s_axis_tvalid/tready      tdata: altitude
//   m_axis    out        m_axis_tvalid/tready      tdata: rgb_color, tuser: range_flag
//   cfg       in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// One item enters per clock when the output is taken. There is one front stage,
// one divider stage per fraction bit and four interpolation stages. Each stage holds
// its own valid bit, so a stall at the output only freezes stages that are full and
// bubbles still close up.
// Reset clears the valid bits and loads elev_min = 0, elev_max = 255.
// Configuration writes are taken in any cycle (cfg_ready is always high).
module elevation_gradient_colormap #(
    parameter int SEGMENTS  = egc_pkg::SEGMENTS_DEF,
    parameter int FRAC_BITS = egc_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [egc_pkg::ELEV_W-1:0]       s_axis_tdata,   // [15:0] altitude
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [egc_pkg::COLOR_W-1:0]      m_axis_tdata,   // [23:0] rgb_color
    output logic                             m_axis_tuser,   // [0] range_flag
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [egc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [egc_pkg::ELEV_W-1:0]       cfg_data
);
    localparam int ACC_W = egc_pkg::ELEV_W + FRAC_BITS;

    logic [egc_pkg::ELEV_W-1:0]   elev_min_reg;
    logic [egc_pkg::ELEV_W-1:0]   elev_max_reg;
    logic signed [egc_pkg::ELEV_W:0] den;

    logic          valid_c [FRAC_BITS+1];
    logic          ready_c [FRAC_BITS+1];
    logic [ACC_W-1:0] acc_c [FRAC_BITS+1];
    egc_pkg::ctl_t ctl_c   [FRAC_BITS+1];

    assign cfg_ready = 1'b1;

    // Write the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elev_min_reg <= egc_pkg::ELEV_MIN_RST;
            elev_max_reg <= egc_pkg::ELEV_MAX_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                egc_pkg::REG_ELEV_MIN: elev_min_reg <= cfg_data;
                egc_pkg::REG_ELEV_MAX: elev_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Range width; keeping it static while items are in flight is up to the user, unenforced by the block
    assign den = {elev_max_reg[egc_pkg::ELEV_W-1], elev_max_reg}
               - {elev_min_reg[egc_pkg::ELEV_W-1], elev_min_reg};

    egc_norm #(
        .FRAC_BITS (FRAC_BITS)
    ) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .altitude  (s_axis_tdata),
        .elev_min  (elev_min_reg),
        .den       (den),
        .out_valid (valid_c[0]),
        .out_ready (ready_c[0]),
        .out_acc   (acc_c[0]),
        .out_ctl   (ctl_c[0])
    );

    // Divider: one quotient bit per stage
    for (genvar i = 0; i < FRAC_BITS; i++)
    begin : g_div
        egc_div_stage #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_c[i]),
            .in_ready  (ready_c[i]),
            .in_acc    (acc_c[i]),
            .in_ctl    (ctl_c[i]),
            .den       (den[egc_pkg::ELEV_W-1:0]),
            .out_valid (valid_c[i+1]),
            .out_ready (ready_c[i+1]),
            .out_acc   (acc_c[i+1]),
            .out_ctl   (ctl_c[i+1])
        );
    end

    egc_lerp #(
        .SEGMENTS  (SEGMENTS),
        .FRAC_BITS (FRAC_BITS)
    ) u_lerp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (valid_c[FRAC_BITS]),
        .in_ready   (ready_c[FRAC_BITS]),
        .in_q       (acc_c[FRAC_BITS][FRAC_BITS-1:0]),
        .in_ctl     (ctl_c[FRAC_BITS]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .rgb_color  (m_axis_tdata),
        .range_flag (m_axis_tuser)
    );

endmodule

// ===== rtl/egc_checker.sv =====
// Port-level checks of the elevation gradient colour map, bound to the top level.
module egc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [egc_pkg::COLOR_W-1:0]   m_axis_tdata,
    input logic                          m_axis_tuser,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [egc_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [egc_pkg::ELEV_W-1:0]    cfg_data
);
    logic signed [egc_pkg::ELEV_W-1:0] min_reg;
    logic signed [egc_pkg::ELEV_W-1:0] max_reg;
    logic [7:0] inflight_reg;
    logic [7:0] inflight_next;
    logic       has_ff;
    logic       has_00;

    // Mirror the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= egc_pkg::ELEV_MIN_RST;
            max_reg <= egc_pkg::ELEV_MAX_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                egc_pkg::REG_ELEV_MIN: min_reg <= cfg_data;
                egc_pkg::REG_ELEV_MAX: max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Count items accepted but not yet delivered
    always_comb
    begin
        inflight_next = inflight_reg + 8'(s_axis_tvalid && s_axis_tready)
                      - 8'(m_axis_tvalid && m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // Every ring segment keeps one channel full and one channel empty
    always_comb
    begin
        has_ff = (m_axis_tdata[23:16] == 8'hFF) || (m_axis_tdata[15:8] == 8'hFF)
              || (m_axis_tdata[7:0] == 8'hFF);
        has_00 = (m_axis_tdata[23:16] == 8'h00) || (m_axis_tdata[15:8] == 8'h00)
              || (m_axis_tdata[7:0] == 8'h00);
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output item changed while stalled");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> inflight_reg != 8'd0)
        else $error("output item without an accepted input item");

    a_ring_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> has_ff && has_00)
        else $error("colour lies off the hue ring");

    a_empty_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (max_reg <= min_reg) |->
            m_axis_tuser && (m_axis_tdata == egc_pkg::HUE_RING[0]))
        else $error("empty range must give the first ring colour and the flag");

endmodule

bind elevation_gradient_colormap egc_checker u_egc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
);

// ===== tb/elevation_gradient_colormap_tb.sv =====
// Self-checking testbench for the elevation gradient colour map: predictor, scoreboard and stimulus.
module elevation_gradient_colormap_tb;

    import egc_pkg::*;

    localparam int SEG_COUNT   = SEGMENTS_DEF;
    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int PIPE_DEPTH  = FRAC + 5;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_OFF    = 300;
    localparam int RAND_PHASES = 13;
    localparam int PHASE_ITEMS = 148;

    // Expected colours for accepted elevation samples, oldest first
    class colour_scoreboard;
        typedef longint unsigned u64_t;
        typedef struct {
            logic [ELEV_W-1:0]  altitude;
            logic [COLOR_W-1:0] colour;
            logic               flag;
        } pixel_t;

        pixel_t            pixel_q[$];
        logic [ELEV_W-1:0] range_lo;
        logic [ELEV_W-1:0] range_hi;
        int                samples;
        int                checked;
        int                flagged;
        int                errors;

        function new();
            range_lo = ELEV_MIN_RST;
            range_hi = ELEV_MAX_RST;
            samples  = 0;
            checked  = 0;
            flagged  = 0;
            errors   = 0;
        endfunction

        function void set_bound(logic [CFG_IDX_W-1:0] idx, logic [ELEV_W-1:0] value);
            if (idx == REG_ELEV_MIN)
            begin
                range_lo = value;
            end
            else if (idx == REG_ELEV_MAX)
            begin
                range_hi = value;
            end
        endfunction

        // Stops of the hue ring: magenta, red, yellow, green, cyan, blue, magenta
        function logic [COLOR_W-1:0] ring_stop(int k);
            case (k)
                0: return 24'hFF00FF;
                1: return 24'hFF0000;
                2: return 24'hFFFF00;
                3: return 24'h00FF00;
                4: return 24'h00FFFF;
                5: return 24'h0000FF;
                default: return 24'hFF00FF;
            endcase
        endfunction

        // Interpolate one channel, rounding the result down in both directions
        function logic [CH_W-1:0] blend(logic [CH_W-1:0] a, logic [CH_W-1:0] b, u64_t t);
            u64_t prod;
            if (b >= a)
            begin
                prod = u64_t'(b - a) * t;
                return a + CH_W'(prod >> FRAC);
            end
            prod = u64_t'(a - b) * t;
            return a - CH_W'((prod + (u64_t'(1) << FRAC) - 1) >> FRAC);
        endfunction

        function pixel_t map_altitude(logic [ELEV_W-1:0] alt);
            pixel_t             p;
            int                 num;
            int                 den;
            u64_t               f;
            u64_t               scaled;
            u64_t               seg;
            u64_t               t;
            int                 k;
            logic [COLOR_W-1:0] c0;
            logic [COLOR_W-1:0] c1;
            p.altitude = alt;
            p.flag     = 1'b0;
            num = int'($signed(alt)) - int'($signed(range_lo));
            den = int'($signed(range_hi)) - int'($signed(range_lo));
            // Empty or inverted range gives the first stop and the flag
            if (den <= 0)
            begin
                p.colour = ring_stop(0);
                p.flag   = 1'b1;
                return p;
            end
            // Normalise and saturate to 0..1
            if (num < 0)
            begin
                f      = 0;
                p.flag = 1'b1;
            end
            else if (num > den)
            begin
                f      = u64_t'(1) << FRAC;
                p.flag = 1'b1;
            end
            else
            begin
                f = (u64_t'(num) << FRAC) / u64_t'(den);
            end
            // Pick the segment; exactly one falls in the last segment at its end
            scaled = f * SEG_COUNT;
            seg    = scaled >> FRAC;
            if (seg >= SEG_COUNT)
            begin
                seg = SEG_COUNT - 1;
            end
            t  = scaled - (seg << FRAC);
            k  = int'(seg % RING_COLORS);
            c0 = ring_stop(k);
            c1 = ring_stop(k + 1);
            p.colour = {blend(c0[23:16], c1[23:16], t),
                        blend(c0[15:8], c1[15:8], t),
                        blend(c0[7:0], c1[7:0], t)};
            return p;
        endfunction

        function void note_sample(logic [ELEV_W-1:0] alt);
            pixel_q.push_back(map_altitude(alt));
            samples++;
        endfunction

        function void check_pixel(logic [COLOR_W-1:0] colour, logic flag);
            pixel_t p;
            if (pixel_q.size() == 0)
            begin
                $display("%0t: result with nothing outstanding: colour %06h flag %0b",
                         $time, colour, flag);
                errors++;
                return;
            end
            p = pixel_q.pop_front();
            checked++;
            if (flag)
            begin
                flagged++;
            end
            if (colour !== p.colour)
            begin
                $display("%0t: rgb_color mismatch, altitude %0d: expected %06h, actual %06h",
                         $time, $signed(p.altitude), p.colour, colour);
                errors++;
            end
            if (flag !== p.flag)
            begin
                $display("%0t: range_flag mismatch, altitude %0d: expected %0b, actual %0b",
                         $time, $signed(p.altitude), p.flag, flag);
                errors++;
            end
        endfunction

        function int outstanding();
            return pixel_q.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [ELEV_W-1:0]    s_axis_tdata = '0;     // [15:0] altitude
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [COLOR_W-1:0]   m_axis_tdata;          // [23:0] rgb_color
    logic                 m_axis_tuser;          // [0] range_flag
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ELEV_W-1:0]    cfg_data = '0;

    colour_scoreboard sb = new();

    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;
    int hold_cycles  = 0;
    int quiet_cycles = 0;
    int reg_writes   = 0;
    int settings     = 0;

    elevation_gradient_colormap #(
        .SEGMENTS  (SEG_COUNT),
        .FRAC_BITS (FRAC)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    // Drive the receiver: a counted hold-off when asked, otherwise random stalls, or always ready with stalls off
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end
            else if (sink_idle_on)
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= 26);
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Check every accepted result
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_pixel(m_axis_tdata, m_axis_tuser);
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, sb.outstanding());
            $display("FAIL elevation_gradient_colormap");
            $finish;
        end
    end

    // Offer one item, with random gaps ahead of it while src_idle_on is set; called and returns at a falling edge
    task automatic send_altitude(input logic [ELEV_W-1:0] alt);
        while (src_idle_on && $urandom_range(0, 99) < 26)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= alt;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        sb.note_sample(alt);
        @(negedge clk);
    endtask

    // Drain the pipe, then write one register
    task automatic write_bound(input logic [CFG_IDX_W-1:0] idx, input logic [ELEV_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
        begin
            @(negedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        sb.set_bound(idx, value);
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_range(input int lo, input int hi);
        write_bound(REG_ELEV_MIN, ELEV_W'(lo));
        write_bound(REG_ELEV_MAX, ELEV_W'(hi));
        settings++;
    endtask

    // Mostly samples inside the range, some around its edges, some anywhere
    function automatic logic [ELEV_W-1:0] pick_altitude(input int lo, input int hi);
        int r;
        r = $urandom_range(0, 99);
        if (hi > lo && r < 70)
        begin
            return ELEV_W'(lo + int'($urandom_range(0, hi - lo)));
        end
        if (r < 80)
        begin
            return ELEV_W'(lo + int'($urandom_range(0, 4)) - 2);
        end
        if (r < 90)
        begin
            return ELEV_W'(hi + int'($urandom_range(0, 4)) - 2);
        end
        return ELEV_W'($urandom_range(0, 65535));
    endfunction

    initial
    begin
        int lo;
        int hi;
        int span;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset range 0..255: ends, middle, just outside, field extremes
        send_altitude(16'sd0);
        send_altitude(16'sd255);
        send_altitude(16'sd128);
        send_altitude(16'sd1);
        send_altitude(16'sd254);
        send_altitude(-16'sd1);
        send_altitude(16'sd256);
        send_altitude(16'h8000);
        send_altitude(16'h7FFF);

        // Range 0..6: every sample lands on a segment boundary, 6 gives exactly one
        set_range(0, 6);
        for (int a = -1; a <= 7; a++)
        begin
            send_altitude(ELEV_W'(a));
        end

        // Empty range, then the most inverted one
        set_range(5, 5);
        send_altitude(16'sd5);
        send_altitude(16'sd0);
        send_altitude(16'h7FFF);
        set_range(32767, -32768);
        send_altitude(16'sd0);
        send_altitude(16'h8000);

        // Random phases, each with its own range
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph % 7)
                0:
                begin
                    lo = -32768;
                    hi = 32767;
                end
                1, 4:
                begin
                    lo = int'($urandom_range(0, 65535)) - 32768;
                    hi = int'($urandom_range(0, 65535)) - 32768;
                    if (hi < lo)
                    begin
                        span = lo;
                        lo   = hi;
                        hi   = span;
                    end
                end
                2, 5:
                begin
                    span = $urandom_range(1, 40);
                    lo   = int'($urandom_range(0, 65535 - span)) - 32768;
                    hi   = lo + span;
                end
                3:
                begin
                    lo = int'($urandom_range(0, 65535)) - 32768;
                    hi = ($urandom_range(0, 1) == 0) ? lo
                         : int'($urandom_range(0, 65535)) - 32768;
                end
                default:
                begin
                    lo = ($urandom_range(0, 1) == 0) ? 32766 : -32768;
                    hi = lo + 1;
                end
            endcase
            set_range(lo, hi);
            // Hold the receiver off so the pipe fills and stalls the input
            if (ph == 2)
            begin
                hold_cycles = HOLD_OFF;
            end
            // One phase at full rate on both sides
            src_idle_on  = (ph != 5);
            sink_idle_on = (ph != 5);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                send_altitude(pick_altitude(lo, hi));
            end
        end

        // Wait for the last results, then keep watching for strays
        s_axis_tvalid <= 1'b0;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b0;
        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_DEPTH + 10) @(posedge clk);

        $display("Covered %0d samples over %0d range settings (%0d register writes).",
                 sb.samples, settings + 1, reg_writes);
        $display("Checked %0d colours, %0d of them flagged out of range; %0d errors.",
                 sb.checked, sb.flagged, sb.errors);
        if (sb.errors == 0 && sb.outstanding() == 0)
        begin
            $display("PASS elevation_gradient_colormap");
        end
        else
        begin
            $display("FAIL elevation_gradient_colormap");
        end
        $finish;
    end

endmodule
